// File: rtl/core/tlwof_pkg.sv
// tlwof_pkg: shared types, register indexes and character width table for the
// text line wrap offset finder. No dependencies.
`timescale 1ns / 1ps

package tlwof_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LINES  = 3'd4;

	// Text modes
	localparam logic [1:0] MODE_DBCS = 2'd0;
	localparam logic [1:0] MODE_LE   = 2'd1;
	localparam logic [1:0] MODE_BE   = 2'd2;

	// Register reset values
	localparam logic [1:0]  RST_TEXT_MODE  = MODE_DBCS;
	localparam logic [7:0]  RST_LINE_WIDTH = 8'd64;
	localparam logic [7:0]  RST_LEAD_LOW   = 8'hB0;
	localparam logic [7:0]  RST_LEAD_HIGH  = 8'hF7;
	localparam logic [15:0] RST_MAX_LINES  = 16'hFFFF;

	// Character codes and width classes
	localparam logic [15:0] NEWLINE_CODE = 16'h000A;
	localparam logic [15:0] NARROW_LIMIT = 16'h007F;
	localparam logic [15:0] MID_LOW      = 16'h0080;
	localparam logic [15:0] MID_HIGH     = 16'h03FF;
	localparam logic [3:0]  W_NARROW     = 4'd4;
	localparam logic [3:0]  W_MID        = 4'd7;
	localparam logic [3:0]  W_WIDE       = 4'd8;
	localparam logic [7:0]  MIN_WIDTH    = 8'd8;

	// Record queue depth (three records at most per byte, plus one slack)
	localparam int unsigned REC_DEPTH = 4;
	localparam int unsigned REC_PTR_W = 2;
	localparam int unsigned REC_CNT_W = 3;

	typedef struct packed {
		logic [1:0]  text_mode;
		logic [7:0]  wrap_width;
		logic [7:0]  lead_low;
		logic [7:0]  lead_high;
		logic [15:0] max_lines;
	} tlwof_cfg_t;

	// Width of a character in half-width units
	function automatic logic [3:0] glyph_units(input logic [15:0] code);
		logic [3:0] w;
		if (code < NARROW_LIMIT) begin
			w = W_NARROW;
		end else if (code inside {[MID_LOW:MID_HIGH]}) begin
			w = W_MID;
		end else begin
			w = W_WIDE;
		end
		return w;
	endfunction

endpackage

// File: rtl/core/tlwof_regs.sv
// tlwof_regs: configuration register file for the line wrap offset finder.
// Depends on tlwof_pkg.
`timescale 1ns / 1ps

module tlwof_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tlwof_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlwof_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tlwof_pkg::tlwof_cfg_t              cfg
);

	tlwof_pkg::tlwof_cfg_t cfg_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_mode  <= tlwof_pkg::RST_TEXT_MODE;
			cfg_q.wrap_width <= tlwof_pkg::RST_LINE_WIDTH;
			cfg_q.lead_low   <= tlwof_pkg::RST_LEAD_LOW;
			cfg_q.lead_high  <= tlwof_pkg::RST_LEAD_HIGH;
			cfg_q.max_lines  <= tlwof_pkg::RST_MAX_LINES;
		end else if (cfg_valid) begin
			case (cfg_index)
				tlwof_pkg::REG_TEXT_MODE:  cfg_q.text_mode  <= cfg_data[1:0];
				tlwof_pkg::REG_LINE_WIDTH: cfg_q.wrap_width <= cfg_data[7:0];
				tlwof_pkg::REG_LEAD_LOW:   cfg_q.lead_low   <= cfg_data[7:0];
				tlwof_pkg::REG_LEAD_HIGH:  cfg_q.lead_high  <= cfg_data[7:0];
				tlwof_pkg::REG_MAX_LINES:  cfg_q.max_lines  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/tlwof_fifo.sv
// tlwof_fifo: small record queue taking up to three records per cycle and
// giving one per cycle while out_pop is high. Depends on tlwof_pkg.
`timescale 1ns / 1ps

module tlwof_fifo #(
	parameter int unsigned REC_W = 50
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [2:0]                          push,
	input  logic [REC_W-1:0]                    rec_a,
	input  logic [REC_W-1:0]                    rec_b,
	input  logic [REC_W-1:0]                    rec_c,
	output logic [tlwof_pkg::REC_CNT_W-1:0]     free,
	output logic                                out_valid,
	input  logic                                out_pop,
	output logic [REC_W-1:0]                    out_rec
);

	logic [REC_W-1:0]                   mem_q [tlwof_pkg::REC_DEPTH];
	logic [tlwof_pkg::REC_PTR_W-1:0]    wr_q;
	logic [tlwof_pkg::REC_PTR_W-1:0]    rd_q;
	logic [tlwof_pkg::REC_CNT_W-1:0]    count_q;
	logic [tlwof_pkg::REC_PTR_W-1:0]    addr_b;
	logic [tlwof_pkg::REC_PTR_W-1:0]    addr_c;
	logic [tlwof_pkg::REC_CNT_W-1:0]    n_push;
	logic                               do_pop;

	// Compacted write slots: each record lands after the ones pushed before it
	assign addr_b = wr_q + tlwof_pkg::REC_PTR_W'(push[0]);
	assign addr_c = wr_q + tlwof_pkg::REC_PTR_W'({1'b0, push[0]} + {1'b0, push[1]});
	assign n_push = tlwof_pkg::REC_CNT_W'({1'b0, push[0]} + {1'b0, push[1]} + {1'b0, push[2]});

	assign free      = tlwof_pkg::REC_CNT_W'(tlwof_pkg::REC_DEPTH) - count_q;
	assign out_valid = (count_q != '0);
	assign out_rec   = mem_q[rd_q];
	assign do_pop    = out_valid && out_pop;

	// Storage
	always_ff @(posedge clk) begin
		if (push[0]) begin
			mem_q[wr_q] <= rec_a;
		end
		if (push[1]) begin
			mem_q[addr_b] <= rec_b;
		end
		if (push[2]) begin
			mem_q[addr_c] <= rec_c;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + tlwof_pkg::REC_PTR_W'(n_push);
			rd_q    <= rd_q + tlwof_pkg::REC_PTR_W'(do_pop);
			count_q <= count_q + n_push - tlwof_pkg::REC_CNT_W'(do_pop);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tlwof_pkg::REC_CNT_W'(tlwof_pkg::REC_DEPTH))
		else $error("record queue over depth");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		n_push <= free)
		else $error("records pushed beyond free space");

endmodule

// File: rtl/core/tlwof_core.sv
// tlwof_core: byte input register, wrap state and per-byte record logic.
// Depends on tlwof_pkg; feeds tlwof_fifo.
`timescale 1ns / 1ps

module tlwof_core #(
	parameter int unsigned OFFSET_BITS = 32,
	parameter int unsigned LINE_BITS   = 16,
	parameter int unsigned REC_W       = LINE_BITS + OFFSET_BITS + 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tlwof_pkg::tlwof_cfg_t              cfg,
	input  logic                               byte_valid,
	output logic                               byte_stall,
	input  logic [7:0]                         text_byte,
	input  logic                               last_byte,
	input  logic [tlwof_pkg::REC_CNT_W-1:0]    free,
	output logic [2:0]                         push,
	output logic [REC_W-1:0]                   rec_a,
	output logic [REC_W-1:0]                   rec_b,
	output logic [REC_W-1:0]                   rec_c
);

	// Input stage
	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    last_s1;

	// Wrap state
	logic [OFFSET_BITS-1:0]  pos_q;
	logic [OFFSET_BITS-1:0]  start_q;
	logic [7:0]              rem_q;
	logic [LINE_BITS-1:0]    lines_q;
	logic [7:0]              hb_q;
	logic                    held_q;
	logic                    stopped_q;

	// Per-byte evaluation
	logic [OFFSET_BITS-1:0]  nxt;
	logic [OFFSET_BITS-1:0]  prv;
	logic                    first;
	logic                    utf16;
	logic [7:0]              eff;
	logic [OFFSET_BITS-1:0]  start0;
	logic [7:0]              rem0;
	logic                    held0;
	logic                    is_lead;
	logic [15:0]             code;
	logic                    hold_now;
	logic                    held1;
	logic [7:0]              hb1;
	logic                    ev_nl;
	logic                    ev_ch;
	logic [3:0]              ch_w;
	logic [OFFSET_BITS-1:0]  ch_off;
	logic                    ov;
	logic                    trig_a;
	logic                    ok_a;
	logic [LINE_BITS-1:0]    lines_a;
	logic                    stop_a;
	logic [OFFSET_BITS-1:0]  start_a;
	logic [7:0]              rem_a;
	logic [7:0]              rem_b;
	logic                    exact;
	logic                    trig_b;
	logic                    ok_b;
	logic [LINE_BITS-1:0]    lines_b;
	logic                    stop_b;
	logic [OFFSET_BITS-1:0]  start_b;
	logic [7:0]              rem_b2;
	logic [1:0]              n_rec;
	logic                    advance;

	always_comb begin
		nxt    = pos_q + OFFSET_BITS'(1);
		prv    = pos_q - OFFSET_BITS'(1);
		first  = (pos_q == '0);
		utf16  = (cfg.text_mode inside {tlwof_pkg::MODE_LE, tlwof_pkg::MODE_BE});
		eff    = (cfg.wrap_width < tlwof_pkg::MIN_WIDTH) ? tlwof_pkg::MIN_WIDTH
		                                                   : cfg.wrap_width;

		// First byte of a text re-seeds the line
		start0 = first ? (utf16 ? OFFSET_BITS'(2) : '0) : start_q;
		rem0   = first ? eff : rem_q;
		held0  = first ? 1'b0 : held_q;

		is_lead = (byte_s1 >= cfg.lead_low) && (byte_s1 <= cfg.lead_high);
		if (utf16) begin
			code = (cfg.text_mode == tlwof_pkg::MODE_BE) ? {hb_q, byte_s1} : {byte_s1, hb_q};
		end else if (held0) begin
			code = {hb_q, byte_s1};
		end else begin
			code = {8'h00, byte_s1};
		end

		// Classify the byte
		hold_now = 1'b0;
		held1    = held0;
		ev_nl    = 1'b0;
		ev_ch    = 1'b0;
		ch_w     = tlwof_pkg::glyph_units(code);
		ch_off   = pos_q;
		if (!stopped_q) begin
			if (utf16) begin
				if (pos_q >= OFFSET_BITS'(2)) begin
					if (!held0) begin
						hold_now = 1'b1;
					end else begin
						held1 = 1'b0;
						if (code == tlwof_pkg::NEWLINE_CODE) begin
							ev_nl = 1'b1;
						end else begin
							ev_ch  = 1'b1;
							ch_off = prv;
						end
					end
				end
			end else if (held0) begin
				held1  = 1'b0;
				ev_ch  = 1'b1;
				ch_off = prv;
			end else if (is_lead) begin
				// lone lead byte at end of text is a wide one-byte character
				if (last_s1) begin
					ev_ch = 1'b1;
					ch_w  = tlwof_pkg::W_WIDE;
				end else begin
					hold_now = 1'b1;
				end
			end else if (code == tlwof_pkg::NEWLINE_CODE) begin
				ev_nl = 1'b1;
			end else begin
				ev_ch = 1'b1;
			end
		end
		hb1 = hb_q;
		if (hold_now) begin
			held1 = 1'b1;
			hb1   = byte_s1;
		end

		// First line record: newline or a character that overflows
		ov      = ev_ch && ({4'b0, ch_w} > rem0);
		trig_a  = ev_nl || ov;
		ok_a    = trig_a && !stopped_q && (16'(lines_q) < cfg.max_lines);
		lines_a = ok_a ? lines_q + LINE_BITS'(1) : lines_q;
		stop_a  = stopped_q || (trig_a && (!ok_a || (16'(lines_a) >= cfg.max_lines)));
		start_a = ev_nl ? nxt : (ov ? ch_off : start0);
		rem_a   = trig_a ? eff : rem0;
		rem_b   = ev_ch ? rem_a - {4'b0, ch_w} : rem_a;

		// Second line record: exact fill, or the partial line at end of text
		exact   = ev_ch && (rem_b == '0);
		trig_b  = exact || (last_s1 && !stop_a && (rem_b != eff));
		ok_b    = trig_b && !stop_a && (16'(lines_a) < cfg.max_lines);
		lines_b = ok_b ? lines_a + LINE_BITS'(1) : lines_a;
		stop_b  = stop_a || (trig_b && (!ok_b || (16'(lines_b) >= cfg.max_lines)));
		start_b = exact ? nxt : start_a;
		rem_b2  = exact ? eff : rem_b;

		// Queue handshake
		n_rec      = 2'({1'b0, ok_a} + {1'b0, ok_b} + {1'b0, last_s1});
		advance    = valid_s1 && ({1'b0, n_rec} <= free);
		byte_stall = valid_s1 && !advance;
		push       = advance ? {last_s1, ok_b, ok_a} : 3'b000;
	end

	// Records: {line_number, line_start, line_valid, text_done}
	assign rec_a = {lines_q, start0, 1'b1, 1'b0};
	assign rec_b = {lines_a, start_a, 1'b1, 1'b0};
	assign rec_c = {lines_b, {OFFSET_BITS{1'b0}}, 1'b0, 1'b1};

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	// Wrap state update, once per byte leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			start_q   <= '0;
			rem_q     <= tlwof_pkg::RST_LINE_WIDTH;
			lines_q   <= '0;
			hb_q      <= '0;
			held_q    <= 1'b0;
			stopped_q <= 1'b0;
		end else if (advance) begin
			start_q <= start_b;
			rem_q   <= rem_b2;
			hb_q    <= hb1;
			if (last_s1) begin
				pos_q     <= '0;
				lines_q   <= '0;
				held_q    <= 1'b0;
				stopped_q <= 1'b0;
			end else begin
				pos_q     <= nxt;
				lines_q   <= lines_b;
				held_q    <= held1;
				stopped_q <= stop_b;
			end
		end
	end

	a_stopped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && stopped_q) |-> (!push[0] && !push[1]))
		else $error("line record after line limit");

	a_text_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (pos_q == '0 && !stopped_q && lines_q == '0))
		else $error("state not restarted after end of text");

	a_count_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push[1] && !push[0]) |-> (16'(lines_q) < cfg.max_lines))
		else $error("line record beyond limit");

endmodule

// File: rtl/core/text_line_wrap_offset_finder.sv
// text_line_wrap_offset_finder: top level of the line wrap offset finder.
// Depends on tlwof_pkg, tlwof_regs, tlwof_core, tlwof_fifo.
//
//   Channel  | Handshake             | Payload
//   ---------+-----------------------+-------------------------------------------
//   byte in  | byte_valid/byte_stall | text_byte, last_byte
//   records  | rec_valid/rec_stall   | line_number, line_start, line_valid, text_done
//   config   | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One byte is accepted per cycle while byte_stall is low; its records enter the queue from
// the input register and leave it one per cycle while rec_stall is low.
// A byte making n records waits in the input register until n queue entries are
// free, so a run of bytes making several records each drops to one record a cycle.
// Reset (arst_n, async) clears the wrap state and loads register defaults.
// A stalled record output fills the queue, then stalls the byte input.
`timescale 1ns / 1ps

module text_line_wrap_offset_finder #(
	parameter int unsigned OFFSET_BITS = 32,
	parameter int unsigned LINE_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tlwof_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tlwof_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [7:0]                        text_byte,
	input  logic                              last_byte,
	output logic                              rec_valid,
	input  logic                              rec_stall,
	output logic [LINE_BITS-1:0]              line_number,
	output logic [OFFSET_BITS-1:0]            line_start,
	output logic                              line_valid,
	output logic                              text_done
);

	localparam int unsigned REC_W = LINE_BITS + OFFSET_BITS + 2;

	tlwof_pkg::tlwof_cfg_t                cfg;
	logic [tlwof_pkg::REC_CNT_W-1:0]      free;
	logic [2:0]                           push;
	logic [REC_W-1:0]                     rec_a;
	logic [REC_W-1:0]                     rec_b;
	logic [REC_W-1:0]                     rec_c;
	logic [REC_W-1:0]                     out_rec;

	tlwof_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tlwof_core #(
		.OFFSET_BITS (OFFSET_BITS),
		.LINE_BITS   (LINE_BITS),
		.REC_W       (REC_W)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.text_byte  (text_byte),
		.last_byte  (last_byte),
		.free       (free),
		.push       (push),
		.rec_a      (rec_a),
		.rec_b      (rec_b),
		.rec_c      (rec_c)
	);

	tlwof_fifo #(
		.REC_W (REC_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rec_a     (rec_a),
		.rec_b     (rec_b),
		.rec_c     (rec_c),
		.free      (free),
		.out_valid (rec_valid),
		.out_pop   (!rec_stall),
		.out_rec   (out_rec)
	);

	// Unpack the head record
	assign line_number = out_rec[REC_W-1 -: LINE_BITS];
	assign line_start  = out_rec[OFFSET_BITS+1 -: OFFSET_BITS];
	assign line_valid  = out_rec[1];
	assign text_done   = out_rec[0];

endmodule

// File: tb/tlwof_line_checker.sv
// tlwof_line_checker: watches the byte, record and config channels of the line wrap
// offset finder, predicts every line record and compares it. Depends on tlwof_pkg.
`timescale 1ns / 1ps

module tlwof_line_checker import tlwof_pkg::*; #(
	parameter int unsigned OFFSET_BITS = 32,
	parameter int unsigned LINE_BITS   = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    byte_valid,
	input  logic                    byte_stall,
	input  logic [7:0]              text_byte,
	input  logic                    last_byte,
	input  logic                    rec_valid,
	input  logic                    rec_stall,
	input  logic [LINE_BITS-1:0]    line_number,
	input  logic [OFFSET_BITS-1:0]  line_start,
	input  logic                    line_valid,
	input  logic                    text_done,
	output int unsigned             mismatch_count,
	output int unsigned             records_pending
);

	typedef struct packed {
		logic [LINE_BITS-1:0]   num;
		logic [OFFSET_BITS-1:0] start;
		logic                   is_line;
		logic                   done;
	} line_rec_t;

	// Shadow registers and wrap state
	tlwof_cfg_t             regs;
	logic [OFFSET_BITS-1:0] byte_pos;
	logic [OFFSET_BITS-1:0] line_begin;
	logic [7:0]             width_left;
	logic [LINE_BITS-1:0]   lines_emitted;
	logic [7:0]             held;
	logic                   held_valid;
	logic                   halted;

	line_rec_t lines_due[$];

	function automatic logic wide_mode();
		return (regs.text_mode == MODE_LE) || (regs.text_mode == MODE_BE);
	endfunction

	// narrow widths are clamped so any character fits an empty line
	function automatic logic [7:0] usable_width();
		return (regs.wrap_width < MIN_WIDTH) ? MIN_WIDTH : regs.wrap_width;
	endfunction

	function automatic logic [3:0] char_units(input logic [15:0] code);
		logic [3:0] units;
		units = W_WIDE;
		if (code < NARROW_LIMIT)
			units = W_NARROW;
		else if (code >= MID_LOW && code <= MID_HIGH)
			units = W_MID;
		return units;
	endfunction

	function automatic void start_text();
		byte_pos      = '0;
		line_begin    = wide_mode() ? OFFSET_BITS'(2) : '0;
		width_left    = usable_width();
		lines_emitted = '0;
		held          = '0;
		held_valid    = 1'b0;
		halted        = 1'b0;
	endfunction

	function automatic void close_line();
		line_rec_t r;
		if (halted || 32'(lines_emitted) >= 32'(regs.max_lines)) begin
			halted = 1'b1;
			return;
		end
		r.num     = lines_emitted;
		r.start   = line_begin;
		r.is_line = 1'b1;
		r.done    = 1'b0;
		lines_due.push_back(r);
		lines_emitted = lines_emitted + 1'b1;
		if (32'(lines_emitted) >= 32'(regs.max_lines))
			halted = 1'b1;
	endfunction

	function automatic void open_line(input logic [OFFSET_BITS-1:0] first);
		line_begin = first;
		width_left = usable_width();
	endfunction

	// a character that overflows starts the next line; an exact fill closes it
	function automatic void fit_char(input logic [3:0] units, input logic [OFFSET_BITS-1:0] at,
			input logic [OFFSET_BITS-1:0] after);
		if (8'(units) > width_left) begin
			close_line();
			open_line(at);
		end
		width_left = width_left - 8'(units);
		if (width_left == '0) begin
			close_line();
			open_line(after);
		end
	endfunction

	function automatic void wrap_byte(input logic [7:0] b, input logic fin);
		logic [OFFSET_BITS-1:0] pos, pos_next, pos_prev;
		logic [15:0]            code;
		line_rec_t              tally;
		pos      = byte_pos;
		pos_next = pos + 1'b1;
		pos_prev = pos - 1'b1;
		if (pos == '0) begin
			line_begin = wide_mode() ? OFFSET_BITS'(2) : '0;
			width_left = usable_width();
			held_valid = 1'b0;
		end
		if (!halted) begin
			if (wide_mode()) begin
				// the byte order mark at offsets 0 and 1 is skipped
				if (pos >= OFFSET_BITS'(2)) begin
					if (!held_valid) begin
						held       = b;
						held_valid = 1'b1;
					end else begin
						code       = (regs.text_mode == MODE_LE) ? {b, held} : {held, b};
						held_valid = 1'b0;
						if (code == NEWLINE_CODE) begin
							close_line();
							open_line(pos_next);
						end else begin
							fit_char(char_units(code), pos_prev, pos_next);
						end
					end
				end
			end else if (held_valid) begin
				held_valid = 1'b0;
				fit_char(char_units({held, b}), pos_prev, pos_next);
			end else if (b >= regs.lead_low && b <= regs.lead_high) begin
				held       = b;
				held_valid = 1'b1;
			end else if (b == NEWLINE_CODE[7:0]) begin
				close_line();
				open_line(pos_next);
			end else begin
				fit_char(char_units({8'h00, b}), pos, pos_next);
			end
		end
		if (fin) begin
			if (!halted) begin
				// a lead byte left dangling at the end is a wide single character
				if (held_valid && !wide_mode())
					fit_char(W_WIDE, pos, pos_next);
				held_valid = 1'b0;
				if (!halted && width_left != usable_width())
					close_line();
			end
			tally.num     = lines_emitted;
			tally.start   = '0;
			tally.is_line = 1'b0;
			tally.done    = 1'b1;
			lines_due.push_back(tally);
			start_text();
		end else begin
			byte_pos = pos_next;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		line_rec_t want;
		if (!arst_n) begin
			regs.text_mode  = RST_TEXT_MODE;
			regs.wrap_width = RST_LINE_WIDTH;
			regs.lead_low   = RST_LEAD_LOW;
			regs.lead_high  = RST_LEAD_HIGH;
			regs.max_lines  = RST_MAX_LINES;
			start_text();
			lines_due.delete();
			mismatch_count  = 0;
			records_pending = 0;
		end else begin
			// compare the record leaving the block against the oldest prediction
			if (rec_valid && !rec_stall) begin
				if (lines_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected record num=%0d start=%0h valid=%b done=%b",
							$time, line_number, line_start, line_valid, text_done);
				end else begin
					want = lines_due.pop_front();
					if (want.num != line_number || want.start != line_start ||
							want.is_line != line_valid || want.done != text_done) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: record mismatch exp num=%0d start=%0h valid=%b done=%b",
								$time, want.num, want.start, want.is_line, want.done);
							$display("    got num=%0d start=%0h valid=%b done=%b",
								line_number, line_start, line_valid, text_done);
						end
					end
				end
			end
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEXT_MODE:  regs.text_mode  = cfg_data[1:0];
					REG_LINE_WIDTH: regs.wrap_width = cfg_data[7:0];
					REG_LEAD_LOW:   regs.lead_low   = cfg_data[7:0];
					REG_LEAD_HIGH:  regs.lead_high  = cfg_data[7:0];
					REG_MAX_LINES:  regs.max_lines  = cfg_data[15:0];
					default: ;
				endcase
			end
			// accepted byte request
			if (byte_valid && !byte_stall)
				wrap_byte(text_byte, last_byte);
			records_pending = lines_due.size();
		end
	end

endmodule

// File: tb/text_line_wrap_offset_finder_tb.sv
// text_line_wrap_offset_finder_tb: drives text and register writes into the line wrap
// offset finder and gives the verdict. Depends on tlwof_pkg and tlwof_line_checker.
`timescale 1ns / 1ps

module text_line_wrap_offset_finder_tb;
	import tlwof_pkg::*;

	localparam int unsigned OFFSET_BITS    = 32;
	localparam int unsigned LINE_BITS      = 16;
	localparam int unsigned RANDOM_BYTES   = 330;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam logic [1:0]  MODE_ALIAS     = 2'd3;	// unused code, behaves as single byte

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   byte_valid;
	logic                   byte_stall;
	logic [7:0]             text_byte;
	logic                   last_byte;
	logic                   rec_valid;
	logic                   rec_stall;
	logic [LINE_BITS-1:0]   line_number;
	logic [OFFSET_BITS-1:0] line_start;
	logic                   line_valid;
	logic                   text_done;
	int unsigned            mismatch_count;
	int unsigned            records_pending;

	logic [7:0]  text_buf[$];
	logic [1:0]  cur_mode;
	logic [7:0]  cur_lo, cur_hi;
	int unsigned burst_left;
	int unsigned random_sent;

	text_line_wrap_offset_finder #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.text_byte(text_byte), .last_byte(last_byte),
		.rec_valid(rec_valid), .rec_stall(rec_stall),
		.line_number(line_number), .line_start(line_start),
		.line_valid(line_valid), .text_done(text_done)
	);

	tlwof_line_checker #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.text_byte(text_byte), .last_byte(last_byte),
		.rec_valid(rec_valid), .rec_stall(rec_stall),
		.line_number(line_number), .line_start(line_start),
		.line_valid(line_valid), .text_done(text_done),
		.mismatch_count(mismatch_count), .records_pending(records_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver stalls: windows of no stall, random stall, or long stall runs
	initial begin
		int unsigned window_left, stall_kind, run_left;
		logic        hold;
		window_left = 0;
		stall_kind  = 0;
		run_left    = 0;
		hold        = 1'b0;
		rec_stall   = 1'b0;
		forever begin
			@(negedge clk);
			if (window_left == 0) begin
				stall_kind  = $urandom_range(2, 0);
				window_left = $urandom_range(200, 20);
			end
			window_left--;
			case (stall_kind)
				0: rec_stall <= 1'b0;
				1: rec_stall <= ($urandom_range(99, 0) < 35);
				default: begin
					if (run_left == 0) begin
						run_left = $urandom_range(12, 1);
						hold     = ~hold;
					end
					run_left--;
					rec_stall <= hold;
				end
			endcase
		end
	end

	// Watchdog: ends the run when nothing is accepted for too long
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((byte_valid && !byte_stall) || (rec_valid && !rec_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// One register write request; the caller lowers cfg_valid after the last one
	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [1:0] mode, input logic [7:0] width,
			input logic [7:0] lo, input logic [7:0] hi, input logic [15:0] max_lines);
		cfg_put(REG_TEXT_MODE, {14'd0, mode});
		cfg_put(REG_LINE_WIDTH, {8'd0, width});
		cfg_put(REG_LEAD_LOW, {8'd0, lo});
		cfg_put(REG_LEAD_HIGH, {8'd0, hi});
		cfg_put(REG_MAX_LINES, max_lines);
		cfg_valid <= 1'b0;
		cur_mode = mode;
		cur_lo   = lo;
		cur_hi   = hi;
	endtask

	// Byte request with bursty gaps in front of it
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
			                                         : $urandom_range(8, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		byte_valid <= 1'b1;
		text_byte  <= b;
		last_byte  <= fin;
		do @(posedge clk); while (byte_stall);
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	// Drain all expected records, then let the block go quiet
	task automatic settle();
		byte_valid <= 1'b0;
		burst_left = 0;
		while (records_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Single-byte text with double-byte pairs from the current lead range
	task automatic build_dbcs(input int unsigned chars);
		int unsigned r;
		text_buf.delete();
		repeat (chars) begin
			r = $urandom_range(99, 0);
			if (r < 10)
				text_buf.push_back(NEWLINE_CODE[7:0]);
			else if (r < 45)
				text_buf.push_back(8'($urandom_range(8'h7E, 8'h20)));
			else if (r < 50)
				text_buf.push_back(8'($urandom_range(8'h1F, 8'h00)));
			else if (r < 55)
				text_buf.push_back(NARROW_LIMIT[7:0]);
			else if (r < 75 && cur_lo <= cur_hi) begin
				text_buf.push_back(8'($urandom_range(cur_hi, cur_lo)));
				text_buf.push_back(8'($urandom_range(255, 0)));
			end else
				text_buf.push_back(8'($urandom_range(8'hFF, 8'h80)));
		end
		// occasionally a lead byte is left alone at the end
		if ($urandom_range(9, 0) == 0)
			text_buf.push_back((cur_lo <= cur_hi) ? 8'($urandom_range(cur_hi, cur_lo)) : cur_lo);
	endtask

	// UTF-16 text: order mark, code units, sometimes an odd trailing byte
	task automatic build_utf16(input int unsigned units);
		int unsigned r;
		logic [15:0] code;
		text_buf.delete();
		if ($urandom_range(9, 0) == 0) begin
			text_buf.push_back(8'($urandom_range(255, 0)));
			text_buf.push_back(8'($urandom_range(255, 0)));
		end else if (cur_mode == MODE_LE) begin
			text_buf.push_back(8'hFF);
			text_buf.push_back(8'hFE);
		end else begin
			text_buf.push_back(8'hFE);
			text_buf.push_back(8'hFF);
		end
		repeat (units) begin
			r = $urandom_range(99, 0);
			if (r < 10)
				code = NEWLINE_CODE;
			else if (r < 45)
				code = 16'($urandom_range(16'h007E, 16'h0020));
			else if (r < 50)
				code = NARROW_LIMIT;
			else if (r < 55)
				code = 16'($urandom_range(16'h001F, 16'h0000));
			else if (r < 75)
				code = 16'($urandom_range(MID_HIGH, MID_LOW));
			else if (r < 95)
				code = 16'($urandom_range(16'hFFFF, 16'h0400));
			else
				code = {NEWLINE_CODE[7:0], 8'($urandom_range(255, 0))};
			if (cur_mode == MODE_LE) begin
				text_buf.push_back(code[7:0]);
				text_buf.push_back(code[15:8]);
			end else begin
				text_buf.push_back(code[15:8]);
				text_buf.push_back(code[7:0]);
			end
		end
		if ($urandom_range(9, 0) == 0)
			text_buf.push_back(8'($urandom_range(255, 0)));
	endtask

	task automatic build_noise(input int unsigned len);
		text_buf.delete();
		repeat (len)
			text_buf.push_back(8'($urandom_range(255, 0)));
	endtask

	// Register setting for one random phase; the first ones hit the extremes
	task automatic pick_regs(input int unsigned phase);
		logic [1:0]  mode;
		logic [7:0]  width, lo, hi, swap;
		logic [15:0] max_lines;
		int unsigned r;
		r    = $urandom_range(99, 0);
		mode = (r < 35) ? MODE_DBCS : (r < 60) ? MODE_LE : (r < 85) ? MODE_BE : MODE_ALIAS;
		r = $urandom_range(9, 0);
		if (r == 0)
			width = 8'($urandom_range(7, 0));
		else if (r == 1)
			width = 8'd255;
		else if (r < 7)
			width = 8'($urandom_range(24, 8));
		else
			width = 8'($urandom_range(254, 25));
		lo = 8'($urandom_range(255, 128));
		hi = 8'($urandom_range(255, 128));
		if (lo > hi && $urandom_range(3, 0) != 0) begin
			swap = lo;
			lo   = hi;
			hi   = swap;
		end
		r = $urandom_range(9, 0);
		if (r == 0)
			max_lines = 16'($urandom_range(3, 1));
		else if (r == 1)
			max_lines = 16'd0;
		else if (r < 6)
			max_lines = 16'hFFFF;
		else
			max_lines = 16'($urandom_range(16'hFFFF, 100));
		case (phase)
			0: set_regs(MODE_DBCS, 8'd255, 8'd128, 8'd255, 16'hFFFF);
			1: set_regs(MODE_LE, 8'd8, lo, hi, 16'd1);
			2: set_regs(MODE_BE, 8'd0, lo, hi, 16'hFFFF);
			3: set_regs(MODE_ALIAS, 8'd8, 8'd255, 8'd128, 16'd4);
			default: set_regs(mode, width, lo, hi, max_lines);
		endcase
	endtask

	initial begin
		int unsigned phase, phase_bytes, phase_target;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		byte_valid  = 1'b0;
		text_byte   = '0;
		last_byte   = 1'b0;
		burst_left  = 0;
		random_sent = 0;
		cur_mode    = RST_TEXT_MODE;
		cur_lo      = RST_LEAD_LOW;
		cur_hi      = RST_LEAD_HIGH;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: newline and a lone lead byte with reset settings
		text_buf = '{8'h41, 8'h0A};
		send_text();
		text_buf = '{8'hB0};
		send_text();
		settle();
		// minimum width: exact fill, overflow, double-byte pair, 0x7F and byte extremes
		set_regs(MODE_DBCS, 8'd8, 8'hB0, 8'hF7, 16'hFFFF);
		text_buf = '{8'h00, 8'h41, 8'h80, 8'h41, 8'hB5, 8'h20, 8'h7F, 8'hFF};
		send_text();
		settle();
		// little endian, narrow width, line limit of two, odd length
		set_regs(MODE_LE, 8'd3, 8'hB0, 8'hF7, 16'd2);
		text_buf = '{8'hFF, 8'hFE, 8'h41, 8'h00, 8'h0A, 8'h00, 8'h80, 8'h00,
			8'h00, 8'h04, 8'h41};
		send_text();
		settle();
		// big endian text too short to hold a character
		set_regs(MODE_BE, 8'd255, 8'hB0, 8'hF7, 16'hFFFF);
		text_buf = '{8'hFE};
		send_text();
		settle();
		// unused mode code, empty lead range, zero line limit
		set_regs(MODE_ALIAS, 8'd0, 8'hF0, 8'h90, 16'd0);
		text_buf = '{8'hF5, 8'h41};
		send_text();
		settle();

		// Random phases, each ending on a text boundary
		phase = 0;
		while (random_sent < RANDOM_BYTES) begin
			pick_regs(phase);
			phase_bytes  = 0;
			phase_target = $urandom_range(60, 30);
			while (phase_bytes < phase_target) begin
				if ($urandom_range(99, 0) < 15)
					build_noise($urandom_range(20, 1));
				else if (cur_mode == MODE_LE || cur_mode == MODE_BE)
					build_utf16($urandom_range(20, 0));
				else
					build_dbcs($urandom_range(30, 1));
				send_text();
				phase_bytes += text_buf.size();
			end
			settle();
			random_sent += phase_bytes;
			phase++;
		end

		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && records_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
